// ===== design/sha224h_pkg.sv =====
// Shared types and constants of the SHA-224 byte stream hasher.
package sha224h_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] vars_t;
	typedef logic [15:0][31:0] sched_t;

	localparam word_t INIT_WORDS [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== design/sha224h_round.sv =====
// One SHA-256 compression round with its message schedule step.
module sha224h_round (
	input  sha224h_pkg::vars_t  v,
	input  sha224h_pkg::sched_t w,
	input  logic                load_phase,
	input  sha224h_pkg::word_t  mem_word,
	input  sha224h_pkg::word_t  k,
	output sha224h_pkg::vars_t  v_next,
	output sha224h_pkg::word_t  w_cur
);
	import sha224h_pkg::*;

	function automatic word_t ror(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	word_t s0;
	word_t s1;
	word_t t1;
	word_t t2;

	always_comb begin
		s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
		s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
		w_cur = load_phase ? mem_word : s1 + w[9] + s0 + w[0];
		t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
			+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w_cur;
		t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
			+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

endmodule

// ===== design/sha224_byte_stream_hasher.sv =====
// SHA-224 byte stream hasher, top level.
//
// Input stream: one beat per message byte (s_tuser low, byte in s_tdata), and one
// end beat (s_tuser high) that closes the message. Output stream: seven 32-bit
// digest words, most significant first, m_tlast on the seventh.
// The beat that fills a 64-byte block starts a compression (a load step, 64
// rounds of the single round unit, a fold into the chaining words); s_tready
// stays low meanwhile. The message words are packed into a 16 x 32 block
// memory and read back one word per round during the first sixteen rounds.
// An end beat generates the padding one byte per cycle between compressions
// (0x80, zeros up to byte 56, then the 64-bit bit length), which costs up to
// 72 padding bytes plus one or two compressions, then offers the seven digest
// beats. A stalled receiver holds the current digest beat; no new input is
// taken until the last digest beat is accepted, after which the chaining
// words and counters are back at their start values.
// Reset loads the SHA-224 initial values and clears the counters; the block
// memory is not cleared and needs no clearing pass.
module sha224_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast
);
	import sha224h_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [1:0] PST_80   = 2'd0;
	localparam logic [1:0] PST_ZERO = 2'd1;
	localparam logic [1:0] PST_LEN  = 2'd2;

	localparam logic [5:0] LEN_OFFSET = 6'd56;

	logic [2:0]  state_q;
	logic [5:0]  off_q;
	logic [63:0] bitlen_q;
	vars_t       chain_q;
	logic [5:0]  rnd_q;
	logic        pad_q;
	logic [1:0]  pst_q;
	logic [2:0]  lidx_q;
	logic        done_q;
	logic [2:0]  oidx_q;

	word_t       asm_q;
	logic [63:0] len_q;
	vars_t       v_q;
	sched_t      w_q;
	word_t       rd_q;
	word_t       mem [16];

	logic        in_fire;
	logic        data_fire;
	logic        end_fire;
	logic        pad_fire;
	logic        byte_fire;
	logic        len_emit;
	logic [7:0]  pad_byte;
	logic [7:0]  byte_val;
	word_t       asm_next;
	logic [3:0]  rd_addr;
	logic        load_phase;
	vars_t       v_next;
	word_t       w_cur;
	logic        out_fire;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid & s_tready;
	assign data_fire = in_fire & ~s_tuser[0];
	assign end_fire  = in_fire & s_tuser[0];
	assign pad_fire  = (state_q == ST_PAD);
	assign byte_fire = data_fire | pad_fire;
	assign len_emit  = pad_fire
		& (((pst_q == PST_ZERO) & (off_q == LEN_OFFSET)) | (pst_q == PST_LEN));

	always_comb begin
		case (pst_q)
			PST_80:   pad_byte = 8'h80;
			PST_ZERO: pad_byte = (off_q == LEN_OFFSET) ? len_q[63:56] : 8'h00;
			PST_LEN:  pad_byte = len_q[63:56];
			default:  pad_byte = 8'h00;
		endcase
	end

	assign byte_val = pad_fire ? pad_byte : s_tdata;
	assign asm_next = (off_q[1:0] == 2'b00) ? {byte_val, 24'h000000}
		: asm_q | (word_t'(byte_val) << {~off_q[1:0], 3'b000});

	assign rd_addr    = (state_q == ST_PREP) ? 4'd0 : rnd_q[3:0] + 4'd1;
	assign load_phase = (rnd_q[5:4] == 2'b00);

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = chain_q[oidx_q];
	assign m_tlast  = (oidx_q == 3'd6);
	assign out_fire = m_tvalid & m_tready;

	sha224h_round u_round (
		.v          (v_q),
		.w          (w_q),
		.load_phase (load_phase),
		.mem_word   (rd_q),
		.k          (ROUND_K[rnd_q]),
		.v_next     (v_next),
		.w_cur      (w_cur)
	);

	always_ff @(posedge clk) begin
		if (byte_fire && off_q[1:0] == 2'b11) begin
			mem[off_q[5:2]] <= asm_next;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (byte_fire) begin
			asm_q <= asm_next;
		end
		if (end_fire) begin
			len_q <= bitlen_q;
		end else if (len_emit) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (state_q == ST_PREP) begin
			v_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			v_q <= v_next;
			w_q <= {w_cur, w_q[15:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			off_q    <= '0;
			bitlen_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_WORDS[i];
			end
			rnd_q    <= '0;
			pad_q    <= 1'b0;
			pst_q    <= PST_80;
			lidx_q   <= '0;
			done_q   <= 1'b0;
			oidx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (data_fire) begin
						bitlen_q <= bitlen_q + 64'd8;
					end
					if (end_fire) begin
						pad_q   <= 1'b1;
						pst_q   <= PST_80;
						done_q  <= 1'b0;
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					case (pst_q)
						PST_80: pst_q <= PST_ZERO;
						PST_ZERO: begin
							if (off_q == LEN_OFFSET) begin
								pst_q  <= PST_LEN;
								lidx_q <= 3'd1;
							end
						end
						PST_LEN: begin
							lidx_q <= lidx_q + 3'd1;
							if (lidx_q == 3'd7) begin
								done_q <= 1'b1;
							end
						end
						default: pst_q <= PST_80;
					endcase
				end
				ST_PREP: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					oidx_q <= '0;
					if (!pad_q) begin
						state_q <= ST_IDLE;
					end else if (done_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd6) begin
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= INIT_WORDS[i];
							end
							bitlen_q <= '0;
							pad_q    <= 1'b0;
							done_q   <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (byte_fire) begin
				off_q <= off_q + 6'd1;
				if (off_q == 6'd63) begin
					state_q <= ST_PREP;
				end
			end
		end
	end

	a_block_full_compresses: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_fire && off_q == 6'd63) |=> (state_q == ST_PREP))
		else $error("full block did not start a compression");

	a_rounds_end_in_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FIN))
		else $error("round 63 not followed by chaining fold");

	a_length_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_fire && pst_q == PST_LEN && lidx_q == 3'd7) |-> (off_q == 6'd63))
		else $error("length bytes not aligned to block end");

	a_digest_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_tlast) |=> (off_q == 6'd0 && bitlen_q == 64'd0
			&& chain_q[0] == INIT_WORDS[0] && state_q == ST_IDLE))
		else $error("state not restored after last digest beat");

endmodule

// ===== verif/sha224_byte_stream_hasher_tb.sv =====
// Self-checking testbench for the SHA-224 byte stream hasher with its own digest predictor.
`timescale 1ns / 100ps

module sha224_byte_stream_hasher_tb;
	import sha224h_pkg::*;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END = 1'b1;
	localparam int MAX_WAIT = 17;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam word_t SHA224_IV [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam word_t SHA2_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic       hold_for_idle;
		logic       action;
		logic [7:0] data;
	} msg_beat_t;

	typedef struct packed {
		word_t word;
		logic  last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	msg_beat_t    pending_beats [$];
	msg_beat_t    cur_beat;
	digest_beat_t digest_words [$];

	word_t       chain_h [8];
	logic [7:0]  blk_bytes [64];
	logic [5:0]  blk_fill;
	logic [63:0] msg_bits;

	int tx_wait;
	int rx_wait;
	bit tx_calm;
	bit rx_calm;
	bit long_hold_done;
	int words_out;
	int mismatches;
	int idle_cycles;

	sha224_byte_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void run_rounds();
		word_t w [64];
		word_t v [8];
		word_t t1;
		word_t t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		v = chain_h;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA2_K[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_h[i] = chain_h[i] + v[i];
	endfunction

	function automatic void absorb(logic [7:0] b);
		blk_bytes[blk_fill] = b;
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0)
			run_rounds();
	endfunction

	function automatic void hash_beat(msg_beat_t bt);
		logic [63:0] len;
		digest_beat_t d;
		if (bt.action == ACT_BYTE) begin
			absorb(bt.data);
			msg_bits = msg_bits + 64'd8;
		end else begin
			len = msg_bits;
			absorb(8'h80);
			while (blk_fill != 6'd56)
				absorb(8'h00);
			for (int i = 7; i >= 0; i--)
				absorb(len[8*i +: 8]);
			for (int i = 0; i < 7; i++) begin
				d.word = chain_h[i];
				d.last = (i == 6);
				digest_words.push_back(d);
			end
			chain_h = SHA224_IV;
			blk_fill = 6'd0;
			msg_bits = 64'd0;
		end
	endfunction

	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void push_beat(logic action, logic [7:0] data, logic hold);
		msg_beat_t bt;
		bt.hold_for_idle = hold;
		bt.action = action;
		bt.data = data;
		pending_beats.push_back(bt);
	endfunction

	function automatic void note_mismatch(digest_beat_t exp_beat, bit none_waiting);
		mismatches++;
		if (mismatches <= 10) begin
			if (none_waiting)
				$display("%0t: digest word %h last %b with none expected",
					$realtime, m_tdata, m_tlast);
			else
				$display("%0t: digest mismatch: expected %h last %b, got %h last %b",
					$realtime, exp_beat.word, exp_beat.last, m_tdata, m_tlast);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver_proc
		logic nxt_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tuser <= ACT_BYTE;
			chain_h = SHA224_IV;
			blk_fill = 6'd0;
			msg_bits = 64'd0;
			tx_wait = 0;
		end else begin
			nxt_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				hash_beat(cur_beat);
				nxt_valid = 1'b0;
				tx_wait = draw_wait(tx_calm);
			end
			if (!nxt_valid) begin
				if (tx_wait > 0) begin
					tx_wait--;
				end else if (pending_beats.size() > 0 &&
						!(pending_beats[0].hold_for_idle && digest_words.size() > 0)) begin
					cur_beat = pending_beats.pop_front();
					nxt_valid = 1'b1;
				end
				if (nxt_valid) begin
					s_tdata <= cur_beat.data;
					s_tuser <= cur_beat.action;
				end else begin
					s_tdata <= 8'($urandom_range(0, 255));
					s_tuser <= 1'($urandom_range(0, 1));
				end
			end
			s_tvalid <= nxt_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor_proc
		logic nxt_ready;
		digest_beat_t exp_beat;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			nxt_ready = m_tready;
			if (m_tvalid && m_tready) begin
				words_out++;
				if (digest_words.size() == 0) begin
					note_mismatch(exp_beat, 1'b1);
				end else begin
					exp_beat = digest_words.pop_front();
					if (m_tdata !== exp_beat.word || m_tlast !== exp_beat.last)
						note_mismatch(exp_beat, 1'b0);
				end
				rx_wait = draw_wait(rx_calm);
				// stall mid-digest so the sender backs up against the held digest
				if (!long_hold_done && words_out >= 60) begin
					rx_wait = LONG_HOLD;
					long_hold_done = 1'b1;
				end
				nxt_ready = 1'b0;
			end
			if (!nxt_ready) begin
				if (rx_wait > 0)
					rx_wait--;
				else
					nxt_ready = 1'b1;
			end
			m_tready <= nxt_ready;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int len;
		// empty messages, the second with a nonzero byte on the end beat
		push_beat(ACT_END, 8'h00, 1'b0);
		push_beat(ACT_END, 8'hff, 1'b0);
		push_beat(ACT_BYTE, 8'h00, 1'b0);
		push_beat(ACT_END, 8'h00, 1'b0);
		push_beat(ACT_BYTE, 8'hff, 1'b1);
		push_beat(ACT_END, 8'ha5, 1'b0);
		push_beat(ACT_BYTE, 8'h61, 1'b0);
		push_beat(ACT_BYTE, 8'h62, 1'b0);
		push_beat(ACT_BYTE, 8'h63, 1'b0);
		push_beat(ACT_END, 8'h5a, 1'b0);
		push_beat(ACT_BYTE, 8'h01, 1'b0);
		push_beat(ACT_BYTE, 8'h80, 1'b0);
		push_beat(ACT_BYTE, 8'h7f, 1'b0);
		push_beat(ACT_END, 8'h00, 1'b0);
		while (pending_beats.size() < 240) begin
			case ($urandom_range(0, 7))
				0: len = $urandom_range(0, 8);
				1: len = 55;
				2: len = 56;
				3: len = $urandom_range(63, 64);
				4: len = $urandom_range(119, 128);
				default: len = $urandom_range(9, 70);
			endcase
			for (int i = 0; i < len; i++)
				push_beat(ACT_BYTE, 8'($urandom_range(0, 255)),
					i == 0 && $urandom_range(0, 5) == 0);
			push_beat(ACT_END, 8'($urandom_range(0, 255)), len == 0 && $urandom_range(0, 1));
		end
		// make sure the drain pause happens at least once in the random part too
		pending_beats[20].hold_for_idle = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_beats.size() != 0 || s_tvalid || digest_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && digest_words.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
